// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the checker file ssnf_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define SSNF_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ssnf check failed: same-cycle implication");

// Consequent checked in the cycle after the antecedent.
`define SSNF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ssnf check failed: next-cycle implication");

`endif

// ===== rtl/core/ssnf_pkg.sv =====
`timescale 1ns / 1ps
package ssnf_pkg;

  localparam int BinWidth   = 31;  // clamped magnitude width
  localparam int DigitCount = 10;  // decimal digits of 2^31-1
  localparam int Positions  = 6;
  localparam int CntWidth   = $clog2(BinWidth);

  localparam logic [1:0] OP_INT   = 2'd0;
  localparam logic [1:0] OP_TIME  = 2'd1;
  localparam logic [1:0] OP_MICRO = 2'd2;

  localparam logic [7:0] SEG_BLANK = 8'h00;
  localparam logic [7:0] SEG_MINUS = 8'h40;
  localparam logic [7:0] SEG_POINT = 8'h80;

  typedef logic [3:0]                      bcd_t;
  typedef logic [DigitCount-1:0][3:0]      bcd_vec_t;
  typedef logic [7:0]                      seg_t;
  typedef logic [Positions-1:0][7:0]       seg_vec_t;

  typedef struct packed {
    logic busy;
    logic done;
  } dbl_stat_t;

  function automatic seg_t seg_of(input bcd_t d);
    seg_t s;
    case (d)
      4'd0:    s = 8'b00111111;
      4'd1:    s = 8'b00000110;
      4'd2:    s = 8'b01011011;
      4'd3:    s = 8'b01001111;
      4'd4:    s = 8'b01100110;
      4'd5:    s = 8'b01101101;
      4'd6:    s = 8'b01111101;
      4'd7:    s = 8'b00000111;
      4'd8:    s = 8'b01111111;
      4'd9:    s = 8'b01101111;
      default: s = SEG_BLANK;
    endcase
    return s;
  endfunction

  // Two-digit field with point on the units position; dashes above 99.
  // Returns {tens, units}.
  function automatic logic [15:0] time_pair(input logic [6:0] v);
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  units;
    logic [15:0] res;
    prod  = 15'(v) * 15'd205;       // v/10 by reciprocal, exact for v < 1029
    tens  = prod[14:11];
    units = v - 7'(tens) * 7'd10;
    if (v > 7'd99) begin
      res = {SEG_MINUS, SEG_MINUS | SEG_POINT};
    end else begin
      res = {seg_of(tens), seg_of(units[3:0]) | SEG_POINT};
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/seven_segment_number_formatter.sv =====
`timescale 1ns / 1ps
// channel | ports                                                           | direction
// input   | in_valid in_stall in_operation in_value in_hours in_minutes in_seconds | req in
// output  | out_valid out_stall out_digit_zero..five                        | segments out
//
// A transaction runs through the bit-serial double-dabble converter (one
// magnitude bit a cycle), its done flag, the ST_HOLD state that formats the
// digits into the output register once the output slot is free, and a return
// to ST_IDLE with in_stall low, where the next transaction can be taken. The
// result is offered through out_valid, registered with the output register.
// rst_n is synchronous and clears the sequencer, converter and output valid.
// in_stall is high from acceptance until the result is loaded; a stalled result
// stays in the output register while the next transaction is taken, and
// out_stall then holds back that load while the next result waits in ST_HOLD.
module seven_segment_number_formatter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic signed [31:0] in_value,
  input  logic [6:0]  in_hours,
  input  logic [6:0]  in_minutes,
  input  logic [6:0]  in_seconds,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_digit_zero,
  output logic [7:0]  out_digit_one,
  output logic [7:0]  out_digit_two,
  output logic [7:0]  out_digit_three,
  output logic [7:0]  out_digit_four,
  output logic [7:0]  out_digit_five
);
  import ssnf_pkg::*;

  // sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;  // ready for a transaction
  localparam logic [1:0] ST_CONV = 2'd1;  // converter shifting
  localparam logic [1:0] ST_HOLD = 2'd2;  // digits ready, waiting for output slot

  logic [1:0]  state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  seg_vec_t    out_r;
  seg_vec_t    segs;

  // captured request
  logic [1:0]  op_r;
  logic        neg_r;
  logic [6:0]  hours_r, minutes_r, seconds_r;

  logic        accept;
  logic        load;
  logic [31:0] mag_full;
  logic [BinWidth-1:0] mag;
  bcd_vec_t    bcd;
  dbl_stat_t   dstat;

  assign accept = in_valid && !in_stall;
  assign load   = (state_r == ST_HOLD) && (!out_valid_r || !out_stall);

  // magnitude; the most negative value clamps to 2^31-1
  always_comb begin
    mag_full = in_value[31] ? (32'd0 - in_value) : in_value;
    mag      = mag_full[31] ? {BinWidth{1'b1}} : mag_full[BinWidth-1:0];
  end

  ssnf_dabble u_dabble (
    .clk   (clk),
    .rst_n (rst_n),
    .start (accept),
    .bin   (mag),
    .bcd   (bcd),
    .stat  (dstat)
  );

  ssnf_format u_format (
    .op      (op_r),
    .neg     (neg_r),
    .digits  (bcd),
    .hours   (hours_r),
    .minutes (minutes_r),
    .seconds (seconds_r),
    .segs    (segs)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_CONV;
      ST_CONV: if (dstat.done) state_nxt = ST_HOLD;
      ST_HOLD: if (load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load)                          out_valid_nxt = 1'b1;
    else if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r      <= in_operation;
      neg_r     <= in_value[31];
      hours_r   <= in_hours;
      minutes_r <= in_minutes;
      seconds_r <= in_seconds;
    end
    if (load) out_r <= segs;
  end

  assign in_stall        = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_digit_zero  = out_r[0];
  assign out_digit_one   = out_r[1];
  assign out_digit_two   = out_r[2];
  assign out_digit_three = out_r[3];
  assign out_digit_four  = out_r[4];
  assign out_digit_five  = out_r[5];

endmodule

// ===== rtl/core/ssnf_dabble.sv =====
`timescale 1ns / 1ps
module ssnf_dabble (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic [ssnf_pkg::BinWidth-1:0]        bin,
  output ssnf_pkg::bcd_vec_t                   bcd,
  output ssnf_pkg::dbl_stat_t                  stat
);
  import ssnf_pkg::*;

  logic [BinWidth-1:0] sh_r, sh_nxt;
  bcd_vec_t            bcd_r, bcd_nxt;
  bcd_vec_t            adj;
  logic [CntWidth-1:0] cnt_r, cnt_nxt;
  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;

  // add-3 correction on every digit before the shift
  always_comb begin
    for (int i = 0; i < DigitCount; i++) begin
      adj[i] = (bcd_r[i] >= 4'd5) ? bcd_r[i] + 4'd3 : bcd_r[i];
    end
  end

  always_comb begin
    sh_nxt   = sh_r;
    bcd_nxt  = bcd_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      sh_nxt   = bin;
      bcd_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // top digit never reaches 8 for a 31-bit magnitude
      bcd_nxt = bcd_vec_t'({adj[DigitCount-1][2:0], adj[DigitCount-2:0],
                            sh_r[BinWidth-1]});
      sh_nxt  = {sh_r[BinWidth-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CntWidth'(BinWidth - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r  <= sh_nxt;
    bcd_r <= bcd_nxt;
  end

  assign bcd       = bcd_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// ===== rtl/core/ssnf_format.sv =====
`timescale 1ns / 1ps
module ssnf_format (
  input  logic [1:0]          op,
  input  logic                neg,
  input  ssnf_pkg::bcd_vec_t  digits,
  input  logic [6:0]          hours,
  input  logic [6:0]          minutes,
  input  logic [6:0]          seconds,
  output ssnf_pkg::seg_vec_t  segs
);
  import ssnf_pkg::*;

  logic [3:0] cnt;    // significant digits of the magnitude
  logic [3:0] ccnt;   // significant digits of magnitude/10
  logic [3:0] shown;
  logic [3:0] idx;
  logic       ovf;

  always_comb begin
    cnt = '0;
    for (int i = 0; i < DigitCount; i++) begin
      if (digits[i] != 4'd0) cnt = 4'(i + 1);
    end
    ccnt = (cnt == 4'd0) ? 4'd0 : cnt - 4'd1;
    ovf  = ccnt > 4'(Positions);
    if (cnt == 4'd0)                shown = 4'd1;
    else if (cnt > 4'(Positions))   shown = 4'(Positions);
    else                            shown = cnt;
    if (ccnt < 4'd3)                idx = 4'd3;
    else if (ovf)                   idx = 4'(Positions);
    else                            idx = ccnt;
  end

  always_comb begin
    segs = '0;
    case (op)
      OP_INT: begin
        for (int i = 0; i < Positions; i++) begin
          if (4'(i) < shown) segs[i] = seg_of(digits[i]);
        end
        if (neg && cnt < 4'(Positions)) segs[Positions-1] = SEG_MINUS;
      end
      OP_TIME: begin
        {segs[5], segs[4]} = time_pair(hours);
        {segs[3], segs[2]} = time_pair(minutes);
        {segs[1], segs[0]} = time_pair(seconds);
      end
      OP_MICRO: begin
        for (int i = 0; i < Positions; i++) begin
          if (4'(i) < idx) segs[i] = seg_of(digits[i+1]);
        end
        segs[2] = segs[2] | SEG_POINT;
        if (neg) begin
          if (idx < 4'(Positions)) segs[idx[2:0]] = SEG_MINUS;
          else                     segs[Positions-1] = SEG_MINUS;
        end
        if (ovf) begin
          for (int i = 0; i < Positions; i++) segs[i] = SEG_MINUS;
        end
      end
      default: segs = '0;
    endcase
  end

endmodule

// ===== rtl/core/ssnf_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ssnf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_digit_zero,
  input logic [7:0]  out_digit_five
);

  // held result keeps its pattern
  `SSNF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_digit_zero) && $stable(out_digit_five))
  // input is stalled right after a transaction is taken
  `SSNF_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  // a new result only comes out of a conversion in progress
  `SSNF_ASSERT_SAME(a_result_from_conv, $rose(out_valid), $past(in_stall))
  // no new result in the cycle after acceptance
  `SSNF_ASSERT_NEXT(a_no_early_result, in_valid && !in_stall, !$rose(out_valid))

endmodule

bind seven_segment_number_formatter ssnf_checker u_ssnf_checker (.*);
